### rtl/lsat_pkg.sv
// Shared types, constants and a helper function of the line sensor array tracker.
package lsat_pkg;

    localparam int NUM_SENSORS   = 11;
    localparam int IDX_W         = $clog2(NUM_SENSORS);
    localparam int SAMPLE_W      = 8;
    localparam int MASK_W        = 11;
    localparam int CENTRE_INDEX  = 5;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    // Register indexes on the configuration port (byte address 4*index).
    localparam logic [1:0] REG_TAPE_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_NEAR_LOW       = 2'd1;
    localparam logic [1:0] REG_NEAR_HIGH      = 2'd2;

    localparam logic [SAMPLE_W-1:0] RESET_TAPE_THRESHOLD = 8'd50;
    localparam logic [SAMPLE_W-1:0] RESET_NEAR_LOW       = 8'd20;
    localparam logic [SAMPLE_W-1:0] RESET_NEAR_HIGH      = 8'd140;

    localparam logic signed [3:0] LEFT_END_OFFSET  = 4'sd4;
    localparam logic signed [3:0] RIGHT_END_OFFSET = -4'sd4;

    localparam logic [7:0] TURN_LEFT_BIT   = 8'h80;
    localparam logic [7:0] TURN_RIGHT_BIT  = 8'h40;
    localparam logic [7:0] TURN_NONE       = 8'h00;
    localparam logic [7:0] TURN_BOTH       = 8'h01;
    localparam logic [7:0] TURN_LEFT_ONLY  = 8'h02;
    localparam logic [7:0] TURN_RIGHT_ONLY = 8'h03;
    localparam logic [7:0] TURN_OVERRIDE   = 8'd193;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic [SAMPLE_W-1:0] sample_4;
        logic [SAMPLE_W-1:0] sample_5;
        logic [SAMPLE_W-1:0] sample_6;
        logic [SAMPLE_W-1:0] sample_7;
        logic [SAMPLE_W-1:0] sample_8;
        logic [SAMPLE_W-1:0] sample_9;
        logic [SAMPLE_W-1:0] sample_10;
        logic [SAMPLE_W-1:0] ir_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [3:0]   line_offset;
        logic [SAMPLE_W-1:0] peak_value;
        logic signed [3:0]   neighbor_offset;
        logic [MASK_W-1:0]   tape_mask;
        logic [7:0]          turn_code;
        logic                obstacle;
    } t_out_item;

    // What one cell hands to the next: the frame and the running search result.
    typedef struct packed {
        t_in_item            frame;
        logic [MASK_W-1:0]   mask;
        logic [IDX_W-1:0]    best_idx;
        logic [SAMPLE_W-1:0] best_val;
        logic [SAMPLE_W-1:0] left_val;
        logic [SAMPLE_W-1:0] right_val;
    } t_chain;

    // Sample of one sensor; positions outside the row read as zero.
    function automatic logic [SAMPLE_W-1:0] get_sample(input t_in_item f,
                                                      input logic [IDX_W-1:0] idx);
        logic [SAMPLE_W-1:0] s;
        case (idx)
            4'd0:    s = f.sample_0;
            4'd1:    s = f.sample_1;
            4'd2:    s = f.sample_2;
            4'd3:    s = f.sample_3;
            4'd4:    s = f.sample_4;
            4'd5:    s = f.sample_5;
            4'd6:    s = f.sample_6;
            4'd7:    s = f.sample_7;
            4'd8:    s = f.sample_8;
            4'd9:    s = f.sample_9;
            4'd10:   s = f.sample_10;
            default: s = '0;
        endcase
        if (int'(idx) >= NUM_SENSORS) begin
            s = '0;
        end
        return s;
    endfunction

endpackage

### rtl/line_sensor_array_tracker_top.sv
// Top level of the line sensor array tracker: register port, cell chain and output stage.
//
// Each input item is one frame of eleven reflectance samples and one IR
// distance sample, offered on i_in_valid / o_in_ready. Each frame gives
// exactly one result item on o_out_valid / i_out_ready, in order.
// The frame walks down a chain of eleven cells, one per sensor. Each cell
// thresholds its own sample into the tape mask and updates the running
// brightest-sensor search. An output stage then forms the neighbor offset,
// turn code and obstacle flag, and registers the result. A new frame is
// accepted every cycle while the receiver keeps up and the chain is not stalled.
// The chain is elastic: each stage holds its item only while the stage
// after it is full and stalled, so when the receiver stalls the bubbles
// close up first and o_in_ready drops only once every stage holds an item.
// Configuration registers are to be written over the APB-style port only
// while the block is idle; the block itself does not enforce this. Synchronous
// active-low reset empties the chain, clears the held neighbor offset to zero
// and sets the registers to their defaults (threshold 50, near window 20 to 140).
module line_sensor_array_tracker_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lsat_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lsat_pkg::t_out_item             o_out_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsat_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lsat_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lsat_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import lsat_pkg::*;

    logic [SAMPLE_W-1:0] r_tape_threshold;
    logic [SAMPLE_W-1:0] r_near_low;
    logic [SAMPLE_W-1:0] r_near_high;

    // Chain links: entry k feeds cell k, entry NUM_SENSORS feeds the output stage.
    logic   w_valid [NUM_SENSORS+1];
    t_chain w_data  [NUM_SENSORS+1];
    logic   w_adv   [NUM_SENSORS+1];

    // The register port never waits.
    assign pready = 1'b1;

    // Register writes land in the access phase; index is the word address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tape_threshold <= RESET_TAPE_THRESHOLD;
            r_near_low       <= RESET_NEAR_LOW;
            r_near_high      <= RESET_NEAR_HIGH;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_TAPE_THRESHOLD: r_tape_threshold <= pwdata[SAMPLE_W-1:0];
                REG_NEAR_LOW:       r_near_low       <= pwdata[SAMPLE_W-1:0];
                REG_NEAR_HIGH:      r_near_high      <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TAPE_THRESHOLD: prdata = APB_DATA_W'(r_tape_threshold);
            REG_NEAR_LOW:       prdata = APB_DATA_W'(r_near_low);
            REG_NEAR_HIGH:      prdata = APB_DATA_W'(r_near_high);
            default:            prdata = '0;
        endcase
    end

    // The first cell sees an empty mask and search; it always takes its sample.
    assign w_valid[0] = i_in_valid;
    assign w_data[0]  = '{frame: i_in_item, mask: '0, best_idx: '0, best_val: '0,
                          left_val: '0, right_val: '0};

    assign o_in_ready = w_adv[0];

    for (genvar k = 0; k < NUM_SENSORS; k++) begin : g_cell
        lsat_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_index     (IDX_W'(k)),
            .i_threshold (r_tape_threshold),
            .i_valid     (w_valid[k]),
            .i_data      (w_data[k]),
            .i_next_adv  (w_adv[k+1]),
            .o_adv       (w_adv[k]),
            .o_valid     (w_valid[k+1]),
            .o_data      (w_data[k+1])
        );
    end

    lsat_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[NUM_SENSORS]),
        .i_data      (w_data[NUM_SENSORS]),
        .i_near_low  (r_near_low),
        .i_near_high (r_near_high),
        .i_out_ready (i_out_ready),
        .o_adv       (w_adv[NUM_SENSORS]),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // Input back-pressure only appears when the whole chain is full and stalled.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while the output side can move");

    // The line offset stays within the sensor row.
    a_line_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.line_offset >= -4'sd5 &&
                         o_out_item.line_offset <= 4'sd5))
        else $error("line offset out of range");

    // Tape under both sensor 2 and sensor 8 forces the override turn code.
    a_turn_override: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.tape_mask[2] && o_out_item.tape_mask[8]) |->
            (o_out_item.turn_code == TURN_OVERRIDE))
        else $error("turn override not applied");

endmodule

### rtl/lsat_cell.sv
// One sensor cell: thresholds its sample and updates the running peak search.
module lsat_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lsat_pkg::IDX_W-1:0]    i_index,
    input  logic [lsat_pkg::SAMPLE_W-1:0] i_threshold,
    input  logic                          i_valid,
    input  lsat_pkg::t_chain              i_data,
    input  logic                          i_next_adv,
    output logic                          o_adv,
    output logic                          o_valid,
    output lsat_pkg::t_chain              o_data
);
    import lsat_pkg::*;

    logic                r_valid;
    t_chain              r_data;
    t_chain              n_data;
    logic [SAMPLE_W-1:0] w_sample;

    // The stage can load when it is empty or its item moves on this cycle.
    assign o_adv = !r_valid || i_next_adv;

    always_comb begin
        n_data   = i_data;
        w_sample = get_sample(i_data.frame, i_index);
        n_data.mask[i_index] = (w_sample >= i_threshold);
        // Strictly greater keeps the lowest index on ties.
        if (i_index == '0 || w_sample > i_data.best_val) begin
            n_data.best_idx  = i_index;
            n_data.best_val  = w_sample;
            n_data.left_val  = get_sample(i_data.frame, IDX_W'(i_index - 1'b1));
            n_data.right_val = get_sample(i_data.frame, IDX_W'(i_index + 1'b1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/lsat_out.sv
// Output stage: neighbor offset with hold, turn code, obstacle flag and result register.
module lsat_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  lsat_pkg::t_chain              i_data,
    input  logic [lsat_pkg::SAMPLE_W-1:0] i_near_low,
    input  logic [lsat_pkg::SAMPLE_W-1:0] i_near_high,
    input  logic                          i_out_ready,
    output logic                          o_adv,
    output logic                          o_out_valid,
    output lsat_pkg::t_out_item           o_out_item
);
    import lsat_pkg::*;

    logic              r_valid;
    t_out_item         r_item;
    t_out_item         n_item;
    logic signed [3:0] r_held;
    logic signed [3:0] n_held;
    logic              w_centre;
    logic              w_left;
    logic              w_right;

    assign o_adv = !r_valid || i_out_ready;

    always_comb begin
        n_held = r_held;
        if (i_data.best_idx == '0) begin
            n_held = LEFT_END_OFFSET;
        end else if (int'(i_data.best_idx) == NUM_SENSORS - 1) begin
            n_held = RIGHT_END_OFFSET;
        end else if (i_data.left_val > i_data.right_val) begin
            n_held = 4'(CENTRE_INDEX + 1 - int'(i_data.best_idx));
        end else if (i_data.left_val < i_data.right_val) begin
            n_held = 4'(CENTRE_INDEX - 1 - int'(i_data.best_idx));
        end

        w_centre = |i_data.mask[6:4];
        w_left   = |i_data.mask[2:0] && w_centre;
        w_right  = |i_data.mask[10:8] && w_centre;

        n_item.line_offset     = 4'(CENTRE_INDEX - int'(i_data.best_idx));
        n_item.peak_value      = i_data.best_val;
        n_item.neighbor_offset = n_held;
        n_item.tape_mask       = i_data.mask;
        if (w_left && w_right) begin
            n_item.turn_code = TURN_BOTH | TURN_LEFT_BIT | TURN_RIGHT_BIT;
        end else if (w_left) begin
            n_item.turn_code = TURN_LEFT_ONLY | TURN_LEFT_BIT;
        end else if (w_right) begin
            n_item.turn_code = TURN_RIGHT_ONLY | TURN_RIGHT_BIT;
        end else begin
            n_item.turn_code = TURN_NONE;
        end
        if (i_data.mask[2] && i_data.mask[8]) begin
            n_item.turn_code = TURN_OVERRIDE;
        end
        n_item.obstacle = (i_data.frame.ir_sample >= i_near_low) &&
                          (i_data.frame.ir_sample < i_near_high);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_held  <= '0;
        end else if (o_adv) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

### test/tb_line_sensor_array_tracker_top.sv
// Self-checking testbench for the line sensor array tracker: frames in, tracking results out.
module tb_line_sensor_array_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsat_pkg::*;

    // The settle pause allows a margin on top of the time the chain holds a frame.
    localparam int LATENCY         = 11;
    localparam int SETTLE_CYCLES   = LATENCY + 8;
    localparam int FRAMES_PER_SET  = 180;
    localparam int NUM_SETTINGS    = 7;
    localparam int HOLD_CYCLES     = 150;
    localparam int MAX_HOLDS       = 3;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int REPORT_LIMIT    = 10;

    // The address decoder leaves index 3 unmapped, so a write there must change nothing.
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    // Clock, reset and every input of the block start at known values.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic       frame_valid  = 1'b0;
    t_in_item   frame_data   = '0;
    logic       result_ready = 1'b0;
    logic       psel         = 1'b0;
    logic       penable      = 1'b0;
    logic       pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr  = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;

    logic       in_ready;
    logic       out_valid;
    t_out_item  out_item;
    logic [APB_DATA_W-1:0] prdata;
    logic       pready;

    line_sensor_array_tracker_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (frame_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (frame_data),
        .o_out_valid (out_valid),
        .i_out_ready (result_ready),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 clk = ~clk;

    // Our own copy of the register file and of the held neighbor offset.
    logic [7:0]        tape_thr  = RESET_TAPE_THRESHOLD;
    logic [7:0]        near_lo   = RESET_NEAR_LOW;
    logic [7:0]        near_hi   = RESET_NEAR_HIGH;
    logic signed [3:0] held_nbr  = '0;

    t_in_item  pending_frames[$];
    t_out_item expected_results[$];

    // Handshake history, written at the rising edge and read at the falling edge.
    bit frame_fire  = 1'b0;
    bit result_fire = 1'b0;

    int frames_accepted = 0;
    int results_checked = 0;
    int fail_count      = 0;
    int settings_used   = 0;
    int holds_done      = 0;
    int cycle_count     = 0;

    // Idling state of both sides. A calm side does not idle at all for a while.
    int   tx_gap  = 0;
    int   rx_gap  = 0;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;
    logic rx_hold = 1'b0;

    // Counts every failure; only the first few are described in the log.
    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // Tracker behavior for one frame. It also advances the held neighbor offset,
    // so it must be called exactly once per accepted frame, in acceptance order.
    function automatic t_out_item predict_track(input t_in_item f);
        logic [7:0]  s [0:10];
        logic [10:0] mask;
        logic [7:0]  turn;
        logic        centre;
        logic        left;
        logic        right;
        int          best;
        t_out_item   r;
        s = '{f.sample_0, f.sample_1, f.sample_2, f.sample_3, f.sample_4, f.sample_5,
              f.sample_6, f.sample_7, f.sample_8, f.sample_9, f.sample_10};
        mask = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (s[i] >= tape_thr) begin
                mask[i] = 1'b1;
            end
        end
        // Strictly-greater search, so the leftmost of equal maxima wins.
        best = 0;
        for (int i = 1; i < NUM_SENSORS; i++) begin
            if (s[best] < s[i]) begin
                best = i;
            end
        end
        // Ends report a fixed offset; equal neighbors leave the held value alone.
        if (best == 0) begin
            held_nbr = LEFT_END_OFFSET;
        end else if (best == NUM_SENSORS - 1) begin
            held_nbr = RIGHT_END_OFFSET;
        end else if (s[best-1] > s[best+1]) begin
            held_nbr = 4'(CENTRE_INDEX - (best - 1));
        end else if (s[best-1] < s[best+1]) begin
            held_nbr = 4'(CENTRE_INDEX - (best + 1));
        end
        centre = |mask[6:4];
        left   = (|mask[2:0]) && centre;
        right  = (|mask[10:8]) && centre;
        if (left && right) begin
            turn = TURN_BOTH;
        end else if (left) begin
            turn = TURN_LEFT_ONLY;
        end else if (right) begin
            turn = TURN_RIGHT_ONLY;
        end else begin
            turn = TURN_NONE;
        end
        if (left) begin
            turn = turn | TURN_LEFT_BIT;
        end
        if (right) begin
            turn = turn | TURN_RIGHT_BIT;
        end
        // Tape under both inner side sensors overrides everything else.
        if (mask[2] && mask[8]) begin
            turn = TURN_OVERRIDE;
        end
        r.line_offset     = 4'(CENTRE_INDEX - best);
        r.peak_value      = s[best];
        r.neighbor_offset = held_nbr;
        r.tape_mask       = mask;
        r.turn_code       = turn;
        r.obstacle        = (f.ir_sample >= near_lo) && (f.ir_sample < near_hi);
        return r;
    endfunction

    function automatic string fmt_result(input t_out_item r);
        return $sformatf("line %0d peak %0d nbr %0d mask %03h turn %02h obst %0b",
                         $signed(r.line_offset), r.peak_value, $signed(r.neighbor_offset),
                         r.tape_mask, r.turn_code, r.obstacle);
    endfunction

    task automatic check_result(input t_out_item want, input t_out_item got);
        string bad;
        bad = "";
        if (got.line_offset !== want.line_offset)         bad = {bad, " line_offset"};
        if (got.peak_value !== want.peak_value)           bad = {bad, " peak_value"};
        if (got.neighbor_offset !== want.neighbor_offset) bad = {bad, " neighbor_offset"};
        if (got.tape_mask !== want.tape_mask)             bad = {bad, " tape_mask"};
        if (got.turn_code !== want.turn_code)             bad = {bad, " turn_code"};
        if (got.obstacle !== want.obstacle)               bad = {bad, " obstacle"};
        if (bad != "") begin
            report_failure($sformatf("Result %0d wrong in%s: expected %s, got %s",
                                     results_checked, bad, fmt_result(want), fmt_result(got)));
        end
        results_checked++;
    endtask

    // Gap length for either side: mostly none or short, now and then a long one.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // One frame per call, row given with sample_0 in the top byte.
    task automatic queue_frame(input logic [87:0] row, input logic [7:0] ir);
        pending_frames.push_back(t_in_item'({row, ir}));
    endtask

    function automatic logic [7:0] clamp_byte(input int v);
        if (v < 0) begin
            return 8'd0;
        end
        if (v > 255) begin
            return 8'd255;
        end
        return 8'(v);
    endfunction

    // Random frame. Most frames look like a real line under the row: a bright
    // ridge over a dim floor, sometimes with one sample set to a random value. The
    // rest are plain noise, equal-neighbor peaks, tied maxima and samples right
    // at the tape threshold. The IR sample often sits on a window boundary.
    function automatic t_in_item rand_frame();
        logic [7:0] s [0:10];
        logic [7:0] ir;
        int kind;
        int pos;
        int peak;
        int spread;
        int slope;
        int d;
        int v;
        kind = $urandom_range(0, 9);
        pos  = $urandom_range(0, 10);
        peak = $urandom_range(0, 255);
        for (int i = 0; i < 11; i++) begin
            s[i] = 8'($urandom_range(0, 40));
        end
        case (kind)
            0, 1, 2, 3, 4, 5: begin
                spread = $urandom_range(0, 3);
                slope  = $urandom_range(1, 60);
                for (int i = 0; i < 11; i++) begin
                    d = (i > pos) ? i - pos : pos - i;
                    v = peak - d * slope;
                    if (d <= spread && v > int'(s[i])) begin
                        s[i] = 8'(v);
                    end
                end
                if ($urandom_range(0, 2) == 0) begin
                    s[$urandom_range(0, 10)] = 8'($urandom_range(0, 255));
                end
            end
            6: begin
                for (int i = 0; i < 11; i++) begin
                    s[i] = 8'($urandom_range(0, 255));
                end
            end
            7: begin
                pos  = $urandom_range(1, 9);
                peak = $urandom_range(1, 255);
                v    = $urandom_range(0, peak - 1);
                for (int i = 0; i < 11; i++) begin
                    s[i] = 8'($urandom_range(0, peak - 1));
                end
                s[pos]   = 8'(peak);
                s[pos-1] = 8'(v);
                s[pos+1] = 8'(v);
            end
            8: begin
                for (int i = 0; i < 11; i++) begin
                    s[i] = 8'($urandom_range(0, peak));
                end
                s[pos] = 8'(peak);
                s[$urandom_range(0, 10)] = 8'(peak);
            end
            default: begin
                for (int i = 0; i < 11; i++) begin
                    s[i] = clamp_byte(int'(tape_thr) + $urandom_range(0, 2) - 1);
                end
            end
        endcase
        case ($urandom_range(0, 3))
            0, 1:    ir = 8'($urandom_range(0, 255));
            2:       ir = clamp_byte(int'(near_lo) + $urandom_range(0, 2) - 1);
            default: ir = clamp_byte(int'(near_hi) + $urandom_range(0, 2) - 1);
        endcase
        return t_in_item'({s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7], s[8], s[9],
                           s[10], ir});
    endfunction

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++) begin
            pending_frames.push_back(rand_frame());
        end
    endtask

    // Hand-picked frames under the reset settings (threshold 50, window 20 to 140).
    task automatic queue_directed();
        queue_frame(88'h00_00_00_00_00_00_00_00_00_00_00, 8'h00); // all dark, peak at left end
        queue_frame(88'hFF_FF_FF_FF_FF_FF_FF_FF_FF_FF_FF, 8'hFF); // all bright, override
        queue_frame(88'h00_00_00_00_00_00_00_00_00_00_FF, 8'd19); // peak at right end
        queue_frame(88'h00_00_00_00_40_C8_40_00_00_00_00, 8'd20); // equal neighbors hold
        queue_frame(88'h00_00_90_A0_10_00_00_00_00_00_00, 8'd139); // left neighbor brighter
        queue_frame(88'h00_00_00_00_00_00_30_F0_80_00_00, 8'd140); // right neighbor brighter
        queue_frame(88'h64_00_00_00_00_64_00_00_00_00_00, 8'h80); // left turn, tied peak
        queue_frame(88'h00_00_00_00_00_70_00_00_00_00_70, 8'h01); // right turn
        queue_frame(88'h00_60_00_00_00_60_00_00_00_60_00, 8'h7F); // both turns
        queue_frame(88'h00_00_60_00_00_00_00_00_60_00_00, 8'h40); // override, no centre
        queue_frame(88'h00_00_00_00_FF_00_FF_00_00_00_00, 8'h8B); // tied peaks, first wins
        queue_frame(88'hC0_D0_20_00_00_00_00_00_00_00_00, 8'h15); // peak next to left end
        queue_frame(88'h00_00_00_00_00_00_00_00_10_E0_20, 8'h8C); // peak next to right end
        queue_frame(88'h32_31_32_31_32_31_32_31_32_31_32, 8'h14); // samples on the threshold
        queue_frame(88'hAA_55_AA_55_AA_55_AA_55_AA_55_AA, 8'hAA); // alternating bits
        queue_frame(88'h55_AA_55_AA_55_AA_55_AA_55_AA_55, 8'h55);
    endtask

    // APB write with a setup and an access phase. Mapped registers are read
    // back afterwards and must return the value just written.
    task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
        logic [APB_DATA_W-1:0] word;
        word = {24'($urandom()), value};
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = word;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_TAPE_THRESHOLD: tape_thr = value;
            REG_NEAR_LOW:       near_lo  = value;
            REG_NEAR_HIGH:      near_hi  = value;
            default: ;
        endcase
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx != REG_UNMAPPED) begin
            @(negedge clk);
            penable = 1'b1;
            do @(posedge clk); while (!pready);
            if (prdata[7:0] !== value) begin
                report_failure($sformatf("Register %0d read back %02h, expected %02h",
                                         idx, prdata[7:0], value));
            end
            @(negedge clk);
        end
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Waits until every queued frame has gone in and every result has come out,
    // then lets the chain settle before the registers may change.
    task automatic drain();
        while (pending_frames.size() != 0 || frame_valid || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both handshakes are sampled here at the rising edge. The result side is
    // handled before the frame side so that a frame accepted on the same edge
    // can never be matched against a result already leaving the block.
    always @(posedge clk) begin : handshake_monitor
        result_fire = rst_n && out_valid && result_ready;
        frame_fire  = rst_n && frame_valid && in_ready;
        if (result_fire) begin
            if (expected_results.size() == 0) begin
                report_failure($sformatf("Result with nothing expected: %s", fmt_result(out_item)));
            end else begin
                check_result(expected_results.pop_front(), out_item);
            end
        end
        if (frame_fire) begin
            expected_results.push_back(predict_track(frame_data));
            frames_accepted++;
        end
    end

    // Frame driver. A frame stays on the port until it is taken; after that the
    // next one is offered after a random gap. During a long receiver hold-off
    // the gaps are skipped so that the chain fills and back-pressure reaches
    // the input.
    always @(negedge clk) begin : frame_driver
        logic     nxt_valid;
        t_in_item nxt_data;
        nxt_valid = frame_valid;
        nxt_data  = frame_data;
        if (!frame_valid || frame_fire) begin
            nxt_valid = 1'b0;
            if (tx_gap != 0 && !rx_hold) begin
                tx_gap--;
            end else if (pending_frames.size() != 0) begin
                nxt_data  = pending_frames.pop_front();
                nxt_valid = 1'b1;
                if ($urandom_range(0, 63) == 0) begin
                    tx_calm = !tx_calm;
                end
                tx_gap = pick_gap(tx_calm);
            end
        end
        frame_valid <= nxt_valid;
        frame_data  <= nxt_data;
    end

    // Result receiver. It stalls at random, both after taking a result and
    // while waiting for one, and stays low for the whole of a long hold-off.
    always @(negedge clk) begin : result_receiver
        logic nxt_ready;
        if (rx_hold) begin
            nxt_ready = 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            nxt_ready = 1'b0;
        end else begin
            if (result_fire || $urandom_range(0, 15) == 0) begin
                if ($urandom_range(0, 63) == 0) begin
                    rx_calm = !rx_calm;
                end
                rx_gap = pick_gap(rx_calm);
            end
            nxt_ready = (rx_gap == 0);
        end
        result_ready <= nxt_ready;
    end

    // Long hold-off of the receiver, a few times in the run, counted here in
    // cycles. The chain is only 12 items deep, so a hold-off with frames offered
    // throughout is far more than enough to fill it and drop o_in_ready.
    always @(negedge clk) begin : long_hold
        int hold_left;
        int hold_at;
        if (hold_at == 0) begin
            hold_at = 300;
        end
        if (hold_left != 0) begin
            hold_left--;
        end else if (holds_done < MAX_HOLDS && frames_accepted >= hold_at) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            hold_at += 400;
        end
        rx_hold <= (hold_left != 0);
    end

    // Watchdog: a stuck handshake ends the run here.
    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Run: directed frames and a random batch under the reset settings, then
    // a batch for each further register setting. The first few settings are
    // the extremes: threshold 0 and 255, a full window, an inverted window, an
    // empty window with equal bounds and a one-value window. The rest are random.
    initial begin : stimulus
        logic [7:0] thr;
        logic [7:0] lo;
        logic [7:0] hi;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        settings_used = 1;
        queue_directed();
        queue_random(FRAMES_PER_SET);
        drain();
        for (int p = 1; p < NUM_SETTINGS; p++) begin
            case (p)
                1: begin thr = 8'd0;   lo = 8'd0;   hi = 8'd255; end
                2: begin thr = 8'd255; lo = 8'd255; hi = 8'd0;   end
                3: begin thr = 8'd128; lo = 8'd100; hi = 8'd100; end
                4: begin thr = 8'd1;   lo = 8'd0;   hi = 8'd1;   end
                default: begin
                    thr = 8'($urandom_range(0, 255));
                    lo  = 8'($urandom_range(0, 255));
                    hi  = 8'($urandom_range(0, 255));
                end
            endcase
            if (p == 3) begin
                reg_write(REG_UNMAPPED, 8'($urandom_range(0, 255)));
            end
            reg_write(REG_TAPE_THRESHOLD, thr);
            reg_write(REG_NEAR_LOW, lo);
            reg_write(REG_NEAR_HIGH, hi);
            settings_used++;
            queue_random(FRAMES_PER_SET);
            drain();
        end
        if (expected_results.size() != 0) begin
            report_failure($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("Run covered %0d frames and %0d checked results over %0d register settings,",
                 frames_accepted, results_checked, settings_used);
        $display("with %0d long receiver hold-offs and %0d failures in %0d cycles.",
                 holds_done, fail_count, cycle_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
